// File: src/in_place_four_neighbour_blur_core_defines.svh
// Assertion macros shared by the blur core checker.
`ifndef IN_PLACE_FOUR_NEIGHBOUR_BLUR_CORE_DEFINES_SVH
`define IN_PLACE_FOUR_NEIGHBOUR_BLUR_CORE_DEFINES_SVH

// Checked out of reset only.
`define IPFNB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ipfnb assertion failed");

// Checked at every edge, reset included.
`define IPFNB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ipfnb assertion failed");

`endif

// File: src/ipfnb_pkg.sv
// Shared constants and types of the in-place four-neighbour blur core.
package ipfnb_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;
  localparam int ResetDim     = 1024;
  localparam int DimMin       = 3;

  localparam int PixW     = 8;
  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 8;

  localparam logic [CfgIdxW-1:0] CfgLineWidth   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  typedef struct packed {
    logic prod;  // primed: transaction yields a result
    logic pass;  // first or last row of a frame, pixel passes raw
    logic last;  // last pixel of a frame
  } item_t;

endpackage

// File: src/ipfnb_ram.sv
// Generic simple dual-port RAM with registered read.
module ipfnb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ipfnb_seq.sv
// Configuration registers and raster position counters of the blur core.
module ipfnb_seq #(
  parameter int MaxWidth  = ipfnb_pkg::MaxWidthDef,
  parameter int MaxHeight = ipfnb_pkg::MaxHeightDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               acc_i,
  input  logic                               cfg_valid_i,
  input  logic [ipfnb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ipfnb_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                               restart_o,
  output logic [$clog2(MaxWidth)-1:0]        col_o,
  output logic [$clog2(MaxWidth)-1:0]        ncol_o,
  output ipfnb_pkg::item_t                   item_o
);

  localparam int CntW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int DimW  = $clog2(MaxWidth + 1);
  localparam int DimHW = $clog2(MaxHeight + 1);
  localparam int ResetW = (ipfnb_pkg::ResetDim > MaxWidth) ? MaxWidth : ipfnb_pkg::ResetDim;
  localparam int ResetH = (ipfnb_pkg::ResetDim > MaxHeight) ? MaxHeight : ipfnb_pkg::ResetDim;

  logic [DimW-1:0]  w_q, w_d;
  logic [DimHW-1:0] h_q, h_d;
  logic [CntW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             primed_q, primed_d;
  logic             wr_w, wr_h, last_col, last_row;

  assign wr_w      = cfg_valid_i && (cfg_index_i == ipfnb_pkg::CfgLineWidth);
  assign wr_h      = cfg_valid_i && (cfg_index_i == ipfnb_pkg::CfgFrameHeight);
  assign restart_o = wr_w || wr_h;

  assign last_col = (DimW'(col_q) + DimW'(1)) == w_q;
  assign last_row = (DimHW'(row_q) + DimHW'(1)) == h_q;

  assign col_o       = col_q;
  assign ncol_o      = last_col ? '0 : col_q + CntW'(1);
  assign item_o.prod = primed_q;
  assign item_o.pass = (row_q == RowW'(0)) || (row_q == RowW'(1));
  assign item_o.last = (row_q == RowW'(0)) && last_col;

  always_comb begin
    w_d      = w_q;
    h_d      = h_q;
    col_d    = col_q;
    row_d    = row_q;
    primed_d = primed_q;
    if (wr_w) begin
      if (cfg_data_i < ipfnb_pkg::CfgDataW'(ipfnb_pkg::DimMin)) begin
        w_d = DimW'(ipfnb_pkg::DimMin);
      end else if (32'(cfg_data_i) > MaxWidth) begin
        w_d = DimW'(MaxWidth);
      end else begin
        w_d = DimW'(cfg_data_i);
      end
    end
    if (wr_h) begin
      if (cfg_data_i < ipfnb_pkg::CfgDataW'(ipfnb_pkg::DimMin)) begin
        h_d = DimHW'(ipfnb_pkg::DimMin);
      end else if (32'(cfg_data_i) > MaxHeight) begin
        h_d = DimHW'(MaxHeight);
      end else begin
        h_d = DimHW'(cfg_data_i);
      end
    end
    if (restart_o) begin
      col_d    = '0;
      row_d    = '0;
      primed_d = 1'b0;
    end else if (acc_i) begin
      if (last_col) begin
        col_d    = '0;
        primed_d = 1'b1;
        row_d    = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= DimW'(ResetW);
      h_q      <= DimHW'(ResetH);
      col_q    <= '0;
      row_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      w_q      <= w_d;
      h_q      <= h_d;
      col_q    <= col_d;
      row_q    <= row_d;
      primed_q <= primed_d;
    end
  end

endmodule

// File: src/ipfnb_out.sv
// Read-data stage, neighbour sum and output register of the blur core.
module ipfnb_out #(
  parameter int CntW = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic                       restart_i,
  input  ipfnb_pkg::item_t           item_i,
  input  logic [CntW-1:0]            col_i,
  input  logic [ipfnb_pkg::PixW-1:0] pix_i,
  input  logic [ipfnb_pkg::PixW-1:0] raw_rd_i,
  input  logic [ipfnb_pkg::PixW-1:0] blur_rd_i,
  output logic                       free_o,
  output logic                       blur_we_o,
  output logic [CntW-1:0]            blur_waddr_o,
  output logic [ipfnb_pkg::PixW-1:0] blur_wdata_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ipfnb_pkg::PixW-1:0] pixel_o,
  output logic                       last_o
);

  localparam int PixW = ipfnb_pkg::PixW;

  logic              s1_valid_q;
  ipfnb_pkg::item_t  s1_item_q;
  logic [CntW-1:0]   s1_col_q;
  logic [PixW-1:0]   s1_pix_q;
  logic [PixW-1:0]   abv_q, prev_q, pixel_q;
  logic              out_valid_q, last_q;
  logic              adv;
  logic [PixW+1:0]   sum;
  logic [PixW-1:0]   result;

  assign adv    = s1_valid_q && (!s1_item_q.prod || !out_valid_q || out_ready_i);
  assign free_o = !s1_valid_q || adv;

  assign sum = {2'b00, raw_rd_i} + {2'b00, prev_q} + {2'b00, blur_rd_i} + {2'b00, s1_pix_q};
  assign result = s1_item_q.pass ? abv_q : sum[PixW+1:2];

  assign blur_we_o    = adv && s1_item_q.prod;
  assign blur_waddr_o = s1_col_q;
  assign blur_wdata_o = result;

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv && s1_item_q.prod) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (restart_i) begin
        prev_q <= '0;
      end else if (adv && s1_item_q.prod) begin
        prev_q <= result;
      end
    end
  end

  // raw read data of one transaction is the pixel above the next one
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_item_q <= item_i;
      s1_col_q  <= col_i;
      s1_pix_q  <= pix_i;
    end
    if (adv) begin
      abv_q <= raw_rd_i;
    end
    if (adv && s1_item_q.prod) begin
      pixel_q <= result;
      last_q  <= s1_item_q.last;
    end
  end

endmodule

// File: src/in_place_four_neighbour_blur_core.sv
// Top level of the in-place four-neighbour blur core.
// Throughput: one pixel per cycle while no held result waits on out_ready_i, set by one
// read and one write per row store per cycle. Path: the accepted transaction passes the
// read-data stage and output register; it comes one frame row after the result's pixel.
// Reset: counters, primed flag and previous output clear; widths return to 1024
// clamped to the maximum; row stores are not cleared.
module in_place_four_neighbour_blur_core #(
  parameter int MaxWidth  = ipfnb_pkg::MaxWidthDef,
  parameter int MaxHeight = ipfnb_pkg::MaxHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ipfnb_pkg::PixW-1:0]     pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ipfnb_pkg::PixW-1:0]     pixel_out_o,
  output logic                           frame_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ipfnb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ipfnb_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CntW = $clog2(MaxWidth);
  localparam int PixW = ipfnb_pkg::PixW;

  logic             acc, restart, free, blur_we;
  logic [CntW-1:0]  col, ncol, blur_waddr;
  logic [PixW-1:0]  raw_rd, blur_rd, blur_wdata;
  ipfnb_pkg::item_t item;

  assign in_ready_o  = free;
  assign acc         = in_valid_i && free;
  assign cfg_ready_o = 1'b1;

  ipfnb_seq #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .restart_o   (restart),
    .col_o       (col),
    .ncol_o      (ncol),
    .item_o      (item)
  );

  ipfnb_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col),
    .wdata_i (pixel_in_i),
    .re_i    (acc),
    .raddr_i (ncol),
    .rdata_o (raw_rd)
  );

  ipfnb_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_blur_ram (
    .clk_i   (clk_i),
    .we_i    (blur_we),
    .waddr_i (blur_waddr),
    .wdata_i (blur_wdata),
    .re_i    (acc),
    .raddr_i (col),
    .rdata_o (blur_rd)
  );

  ipfnb_out #(
    .CntW (CntW)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .restart_i    (restart),
    .item_i       (item),
    .col_i        (col),
    .pix_i        (pixel_in_i),
    .raw_rd_i     (raw_rd),
    .blur_rd_i    (blur_rd),
    .free_o       (free),
    .blur_we_o    (blur_we),
    .blur_waddr_o (blur_waddr),
    .blur_wdata_o (blur_wdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_o      (pixel_out_o),
    .last_o       (frame_last_o)
  );

endmodule

// File: src/ipfnb_chk.sv
// Port-level assertion checker of the blur core and its bind.
`include "in_place_four_neighbour_blur_core_defines.svh"

module ipfnb_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ipfnb_pkg::PixW-1:0] pixel_out_i,
  input logic                       frame_last_i
);

  `IPFNB_ASSERT(out_valid_held, out_valid_i && !out_ready_i |=> out_valid_i)
  `IPFNB_ASSERT(out_data_held, out_valid_i && !out_ready_i |=> $stable(pixel_out_i) && $stable(frame_last_i))
  `IPFNB_ASSERT(ready_when_out_free, !out_valid_i |-> in_ready_i)
  `IPFNB_ASSERT_ALWAYS(no_out_in_reset, !rst_ni |-> !out_valid_i)

endmodule

bind in_place_four_neighbour_blur_core ipfnb_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ready_o),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pixel_out_i  (pixel_out_o),
  .frame_last_i (frame_last_o)
);
